/* design/grid_depth_first_search_stepper_unit_macros.svh */
// ----------------------------------------------------------------------------
// Grid depth-first search stepper assertion macros
// Concurrent assertion helpers shared by the stepper RTL.
// ----------------------------------------------------------------------------
`ifndef GRID_DEPTH_FIRST_SEARCH_STEPPER_UNIT_MACROS_SVH
`define GRID_DEPTH_FIRST_SEARCH_STEPPER_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define GDFS_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define GDFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/gdfs_pkg.sv */
// ----------------------------------------------------------------------------
// Grid depth-first search stepper package
// Sizes, codes, payload types and address helpers shared by the stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package gdfs_pkg;

  localparam int MAX_COLS    = 64;
  localparam int MAX_ROWS    = 64;
  localparam int STACK_DEPTH = 8192;

  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int MAP_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int STK_AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W     = STK_AW + 1;
  localparam int ENTRY_W   = COL_W + ROW_W;

  localparam int DIM_W      = 7;
  localparam int COORD_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int NUM_DIRS   = 8;
  localparam int DIR_W      = $clog2(NUM_DIRS + 1);

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_STEP    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_LOOKING = 2'd0,
    STATUS_GOAL    = 2'd1,
    STATUS_UNABLE  = 2'd2,
    STATUS_DONE    = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW    = 3'd5;

  typedef struct packed {
    cmd_t               command;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
    logic               cell_blocked;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [COORD_W-1:0] node_col;
    logic [COORD_W-1:0] node_row;
    logic               stack_overflow;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]   grid_width;
    logic [DIM_W-1:0]   grid_height;
    logic [COORD_W-1:0] start_col;
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] goal_col;
    logic [COORD_W-1:0] goal_row;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cell_t;

  function automatic logic [MAP_AW-1:0] map_addr(cell_t c);
    return MAP_AW'(int'(c.col) + MAX_COLS * int'(c.row));
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v, int max_v);
    logic [DIM_W-1:0] d;
    d = v;
    if (v == '0) d = DIM_W'(1);
    if (int'(v) > max_v) d = DIM_W'(max_v);
    return d;
  endfunction

endpackage

`default_nettype wire

/* design/gdfs_ram.sv */
// ----------------------------------------------------------------------------
// Grid depth-first search stepper RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gdfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/gdfs_ctrl.sv */
// ----------------------------------------------------------------------------
// Grid depth-first search stepper sequencer
// Owns the blocked map, visited map and stack memories and sequences load,
// restart and search step commands over them.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_depth_first_search_stepper_unit_macros.svh"

module gdfs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gdfs_pkg::cfg_t      cfg,
  input  wire logic                in_valid,
  input  wire gdfs_pkg::in_item_t  in_data,
  output logic                     in_stall,
  output logic                     res_valid,
  output gdfs_pkg::out_item_t      res_data,
  input  wire logic                res_ready
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_CLEAR, S_START, S_POPPED, S_TOP, S_SCAN, S_DONE
  } state_t;

  typedef enum logic [gdfs_pkg::DIR_W-1:0] {
    D_E, D_SE, D_S, D_SW, D_W, D_NW, D_N, D_NE, D_END
  } dir_t;

  state_t                          state_r, state_nxt;
  logic [gdfs_pkg::MAP_AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [gdfs_pkg::CNT_W-1:0]      count_r, count_nxt;
  gdfs_pkg::cell_t                 node_r, node_nxt;
  gdfs_pkg::cell_t                 top_r, top_nxt;
  logic                            top_v_r, top_v_nxt;
  dir_t                            dir_r, dir_nxt;
  logic                            chk_v_r, chk_v_nxt;
  gdfs_pkg::cell_t                 chk_r, chk_nxt;
  logic                            ovf_r, ovf_nxt;
  gdfs_pkg::status_t               status_r, status_nxt;
  logic                            fe_r, fe_nxt, fs_r, fs_nxt;
  logic                            fw_r, fw_nxt, fn_r, fn_nxt;

  logic                            blk_we, vis_we, blk_wdata, vis_wdata;
  logic [gdfs_pkg::MAP_AW-1:0]     blk_waddr, vis_waddr, map_raddr;
  logic                            blk_rd, vis_rd;
  logic                            stk_we;
  logic [gdfs_pkg::STK_AW-1:0]     stk_waddr, stk_raddr;
  logic [gdfs_pkg::ENTRY_W-1:0]    stk_wdata, stk_rd;

  logic [gdfs_pkg::DIM_W-1:0]      eff_w, eff_h;
  gdfs_pkg::cell_t                 start_cell, popped, load_cell, nb;
  logic                            start_ok, load_ok, nb_ok, cand_free, push, drop, accept;

  gdfs_ram #(.WIDTH(1), .DEPTH(gdfs_pkg::MAP_DEPTH)) u_blk_ram (
    .clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
    .raddr(map_raddr), .rdata(blk_rd)
  );

  gdfs_ram #(.WIDTH(1), .DEPTH(gdfs_pkg::MAP_DEPTH)) u_vis_ram (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(map_raddr), .rdata(vis_rd)
  );

  gdfs_ram #(.WIDTH(gdfs_pkg::ENTRY_W), .DEPTH(gdfs_pkg::STACK_DEPTH)) u_stk_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd)
  );

  assign eff_w = gdfs_pkg::eff_dim(cfg.grid_width, gdfs_pkg::MAX_COLS);
  assign eff_h = gdfs_pkg::eff_dim(cfg.grid_height, gdfs_pkg::MAX_ROWS);

  assign start_cell.col = gdfs_pkg::COL_W'(cfg.start_col);
  assign start_cell.row = gdfs_pkg::ROW_W'(cfg.start_row);
  assign start_ok = (int'(cfg.start_col) < int'(eff_w)) &&
                    (int'(cfg.start_row) < int'(eff_h));

  assign load_cell.col = gdfs_pkg::COL_W'(in_data.cell_col);
  assign load_cell.row = gdfs_pkg::ROW_W'(in_data.cell_row);
  assign load_ok = (int'(in_data.cell_col) < gdfs_pkg::MAX_COLS) &&
                   (int'(in_data.cell_row) < gdfs_pkg::MAX_ROWS);

  assign popped = gdfs_pkg::cell_t'(stk_rd);
  assign accept = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    nb    = node_r;
    nb_ok = 1'b0;
    case (dir_r)
      D_E: begin
        nb.col = node_r.col + gdfs_pkg::COL_W'(1);
        nb_ok  = fe_r;
      end
      D_SE: begin
        nb.col = node_r.col + gdfs_pkg::COL_W'(1);
        nb.row = node_r.row + gdfs_pkg::ROW_W'(1);
        nb_ok  = fe_r && fs_r;
      end
      D_S: begin
        nb.row = node_r.row + gdfs_pkg::ROW_W'(1);
        nb_ok  = fs_r;
      end
      D_SW: begin
        nb.col = node_r.col - gdfs_pkg::COL_W'(1);
        nb.row = node_r.row + gdfs_pkg::ROW_W'(1);
        nb_ok  = fw_r && fs_r;
      end
      D_W: begin
        nb.col = node_r.col - gdfs_pkg::COL_W'(1);
        nb_ok  = fw_r;
      end
      D_NW: begin
        nb.col = node_r.col - gdfs_pkg::COL_W'(1);
        nb.row = node_r.row - gdfs_pkg::ROW_W'(1);
        nb_ok  = fw_r && fn_r;
      end
      D_N: begin
        nb.row = node_r.row - gdfs_pkg::ROW_W'(1);
        nb_ok  = fn_r;
      end
      D_NE: begin
        nb.col = node_r.col + gdfs_pkg::COL_W'(1);
        nb.row = node_r.row - gdfs_pkg::ROW_W'(1);
        nb_ok  = fe_r && fn_r;
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign cand_free = chk_v_r && !blk_rd && !vis_rd && !(top_v_r && (top_r == chk_r));
  assign push = cand_free && (int'(count_r) < gdfs_pkg::STACK_DEPTH);
  assign drop = cand_free && !(int'(count_r) < gdfs_pkg::STACK_DEPTH);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    count_nxt    = count_r;
    node_nxt     = node_r;
    top_nxt      = top_r;
    top_v_nxt    = top_v_r;
    dir_nxt      = dir_r;
    chk_v_nxt    = chk_v_r;
    chk_nxt      = chk_r;
    ovf_nxt      = ovf_r;
    status_nxt   = status_r;
    fe_nxt       = fe_r;
    fs_nxt       = fs_r;
    fw_nxt       = fw_r;
    fn_nxt       = fn_r;
    blk_we       = 1'b0;
    blk_waddr    = clr_addr_r;
    blk_wdata    = 1'b0;
    vis_we       = 1'b0;
    vis_waddr    = clr_addr_r;
    vis_wdata    = 1'b0;
    map_raddr    = gdfs_pkg::map_addr(nb);
    stk_we       = 1'b0;
    stk_waddr    = count_r[gdfs_pkg::STK_AW-1:0];
    stk_wdata    = chk_r;
    stk_raddr    = gdfs_pkg::STK_AW'(count_r - gdfs_pkg::CNT_W'(1));

    case (state_r)
      S_INIT: begin
        blk_we       = 1'b1;
        vis_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + gdfs_pkg::MAP_AW'(1);
        if (clr_addr_r == gdfs_pkg::MAP_AW'(gdfs_pkg::MAP_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          node_nxt   = '0;
          ovf_nxt    = 1'b0;
          status_nxt = gdfs_pkg::STATUS_DONE;
          state_nxt  = S_DONE;
          case (in_data.command)
            gdfs_pkg::CMD_LOAD: begin
              blk_we    = load_ok;
              blk_waddr = gdfs_pkg::map_addr(load_cell);
              blk_wdata = in_data.cell_blocked;
            end
            gdfs_pkg::CMD_RESTART: begin
              clr_addr_nxt = '0;
              state_nxt    = S_CLEAR;
            end
            gdfs_pkg::CMD_STEP: begin
              if (count_r == '0) begin
                status_nxt = gdfs_pkg::STATUS_UNABLE;
              end else begin
                count_nxt = count_r - gdfs_pkg::CNT_W'(1);
                state_nxt = S_POPPED;
              end
            end
            default: begin
              status_nxt = gdfs_pkg::STATUS_DONE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        vis_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + gdfs_pkg::MAP_AW'(1);
        if (clr_addr_r == gdfs_pkg::MAP_AW'(gdfs_pkg::MAP_DEPTH - 1)) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        count_nxt = '0;
        if (start_ok) begin
          vis_we    = 1'b1;
          vis_waddr = gdfs_pkg::map_addr(start_cell);
          vis_wdata = 1'b1;
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = start_cell;
          count_nxt = gdfs_pkg::CNT_W'(1);
        end
        state_nxt = S_DONE;
      end
      S_POPPED: begin
        node_nxt  = popped;
        vis_we    = 1'b1;
        vis_waddr = gdfs_pkg::map_addr(popped);
        vis_wdata = 1'b1;
        if ((int'(popped.col) == int'(cfg.goal_col)) &&
            (int'(popped.row) == int'(cfg.goal_row))) begin
          status_nxt = gdfs_pkg::STATUS_GOAL;
          state_nxt  = S_DONE;
        end else begin
          status_nxt = gdfs_pkg::STATUS_LOOKING;
          fe_nxt     = int'(popped.col) < int'(eff_w) - 1;
          fs_nxt     = int'(popped.row) < int'(eff_h) - 1;
          fw_nxt     = popped.col != '0;
          fn_nxt     = popped.row != '0;
          top_v_nxt  = 1'b0;
          dir_nxt    = D_E;
          chk_v_nxt  = 1'b0;
          state_nxt  = (count_r != '0) ? S_TOP : S_SCAN;
        end
      end
      S_TOP: begin
        top_nxt   = gdfs_pkg::cell_t'(stk_rd);
        top_v_nxt = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (dir_r != D_END) begin
          chk_v_nxt = nb_ok;
          chk_nxt   = nb;
          dir_nxt   = dir_t'(gdfs_pkg::DIR_W'(dir_r) + gdfs_pkg::DIR_W'(1));
        end else begin
          chk_v_nxt = 1'b0;
          state_nxt = S_DONE;
        end
        if (push) begin
          stk_we    = 1'b1;
          count_nxt = count_r + gdfs_pkg::CNT_W'(1);
          top_nxt   = chk_r;
          top_v_nxt = 1'b1;
        end
        if (drop) begin
          ovf_nxt = 1'b1;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      clr_addr_r <= '0;
      count_r    <= '0;
      top_v_r    <= 1'b0;
      chk_v_r    <= 1'b0;
      dir_r      <= D_E;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      count_r    <= count_nxt;
      top_v_r    <= top_v_nxt;
      chk_v_r    <= chk_v_nxt;
      dir_r      <= dir_nxt;
      node_r     <= node_nxt;
      top_r      <= top_nxt;
      chk_r      <= chk_nxt;
      ovf_r      <= ovf_nxt;
      status_r   <= status_nxt;
      fe_r       <= fe_nxt;
      fs_r       <= fs_nxt;
      fw_r       <= fw_nxt;
      fn_r       <= fn_nxt;
    end
  end

  assign res_valid               = (state_r == S_DONE);
  assign res_data.status         = status_r;
  assign res_data.node_col       = gdfs_pkg::COORD_W'(node_r.col);
  assign res_data.node_row       = gdfs_pkg::COORD_W'(node_r.row);
  assign res_data.stack_overflow = ovf_r;

  `GDFS_ASSERT_HOLDS(a_count_bound, clk, rst_n, 1'b1,
    int'(count_r) <= gdfs_pkg::STACK_DEPTH, "Stack count exceeds the stack depth.")
  `GDFS_ASSERT_NEXT(a_push_count, clk, rst_n, (state_r == S_SCAN) && push,
    count_r == $past(count_r) + gdfs_pkg::CNT_W'(1), "A push did not grow the stack by one.")
  `GDFS_ASSERT_HOLDS(a_empty_no_top, clk, rst_n, (state_r == S_SCAN) && (count_r == '0),
    !top_v_r, "Top of stack is marked valid while the stack is empty.")

endmodule

`default_nettype wire

/* design/grid_depth_first_search_stepper_unit.sv */
// ----------------------------------------------------------------------------
// Grid depth-first search stepper unit
// Each transfer on the input channel is one command (load a blocked flag,
// restart the search, take one search step or do nothing) and yields exactly
// one result transfer. A search step that scans the neighbors reads the stack
// top on acceptance, marks the popped entry visited, fetches the new top, scans
// the eight neighbors, where the blocked and visited memory reads for one
// neighbor overlap the push decision for the one before, and then hands the
// result over. When the pop leaves the stack empty there is no new top to fetch.
// Steps that find an empty stack or the goal, loads and no-op commands skip
// the neighbor scan. A restart sweeps the 4096-entry visited memory one entry
// per cycle. After reset a clearing pass over the 4096 entries of the blocked
// and visited memories runs before the first input is accepted; configuration
// writes are taken at all times. A new command is accepted only once the last
// result has been handed over; results wait in an output register, so the next
// command is accepted while a result is still stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_depth_first_search_stepper_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire gdfs_pkg::in_item_t                   in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output gdfs_pkg::out_item_t                       out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [gdfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gdfs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  gdfs_pkg::cfg_t      cfg_r;
  logic                out_valid_r;
  gdfs_pkg::out_item_t out_data_r;
  logic                res_valid, res_ready;
  gdfs_pkg::out_item_t res_data;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width  <= gdfs_pkg::DIM_W'(gdfs_pkg::MAX_COLS);
      cfg_r.grid_height <= gdfs_pkg::DIM_W'(gdfs_pkg::MAX_ROWS);
      cfg_r.start_col   <= '0;
      cfg_r.start_row   <= '0;
      cfg_r.goal_col    <= '0;
      cfg_r.goal_row    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gdfs_pkg::REG_GRID_WIDTH:  cfg_r.grid_width  <= gdfs_pkg::DIM_W'(cfg_data);
        gdfs_pkg::REG_GRID_HEIGHT: cfg_r.grid_height <= gdfs_pkg::DIM_W'(cfg_data);
        gdfs_pkg::REG_START_COL:   cfg_r.start_col   <= gdfs_pkg::COORD_W'(cfg_data);
        gdfs_pkg::REG_START_ROW:   cfg_r.start_row   <= gdfs_pkg::COORD_W'(cfg_data);
        gdfs_pkg::REG_GOAL_COL:    cfg_r.goal_col    <= gdfs_pkg::COORD_W'(cfg_data);
        gdfs_pkg::REG_GOAL_ROW:    cfg_r.goal_row    <= gdfs_pkg::COORD_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  gdfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
      out_data_r  <= res_data;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
